### rtl/power_of_two_free_list_allocator_unit_macros.svh
// Assertion macros for the power-of-two free-list allocator.
// Included by the allocator unit, which checks its own logic; no other dependencies.
`ifndef POWER_OF_TWO_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define POWER_OF_TWO_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define P2FLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define P2FLA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define P2FLA_ASSERT(lbl, prop, msg)
`define P2FLA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

### rtl/p2fla_pkg.sv
// Shared types, constants and helper functions of the free-list allocator.
// No dependencies; imported by the decode module, the allocator unit and the testbench.
`default_nettype none
package p2fla_pkg;

  localparam int NCLASS      = 9;
  localparam int CLS_W       = 4;
  localparam int SLOT_W      = 8;
  localparam int ADDR_W      = 19;
  localparam int SIZE_W      = 13;
  localparam int OFF_W       = 13;
  localparam int PAGE_ADDR_W = ADDR_W - OFF_W;
  localparam int PAGE_BYTES  = 8192;
  localparam int LIVE_W      = 14;
  localparam int MIN_SHIFT   = 5;

  localparam logic [CLS_W-1:0] NO_CLASS = 4'd15;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_PAGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_POP_WAIT,
    S_CARVE,
    S_BUF_RD,
    S_BUF_WB,
    S_FREE_INFO,
    S_FREE_CHK,
    S_FREE_BUF,
    S_FREE_WB,
    S_REL_RD,
    S_REL_WB
  } state_t;

  typedef struct packed {
    logic             too_large;
    logic [CLS_W-1:0] cls;
  } alloc_dec_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } free_dec_t;

  // Buffers carved from one page of class k, never fewer than one.
  function automatic logic [SLOT_W:0] bufs_per_page(input logic [CLS_W-1:0] k,
                                                    input logic [OFF_W-1:0] usable);
    logic [OFF_W-1:0] n;
    n = usable >> ({1'b0, k} + 5'(MIN_SHIFT));
    return (n == '0) ? (SLOT_W+1)'(1) : n[SLOT_W:0];
  endfunction

endpackage
`default_nettype wire

### rtl/p2fla_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module p2fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/p2fla_decode.sv
// Size-class selection, free-address decoding and data-address offset.
// Depends on p2fla_pkg.
`default_nettype none
module p2fla_decode import p2fla_pkg::*; #(
  parameter int PTR_BYTES      = 8,
  parameter int PAGE_HDR_BYTES = 16
) (
  input  logic [SIZE_W-1:0] size,
  input  logic [OFF_W-1:0]  off,
  input  logic [CLS_W-1:0]  free_cls,
  input  logic [SLOT_W-1:0] slot,
  input  logic [CLS_W-1:0]  addr_cls,
  output alloc_dec_t        adec,
  output free_dec_t         fdec,
  output logic [OFF_W-1:0]  data_off
);

  localparam logic [OFF_W-1:0] BASE   = OFF_W'(PAGE_HDR_BYTES + PTR_BYTES);
  localparam logic [OFF_W-1:0] USABLE = OFF_W'(PAGE_BYTES - PAGE_HDR_BYTES);

  logic [SIZE_W:0]       need;
  logic [OFF_W-1:0]      rel;
  logic [4:0]            fshift;
  logic [OFF_W:0]        mask;
  logic [OFF_W-1:0]      slot_full;
  logic [SLOT_W:0]       nbuf;
  logic [OFF_W+SLOT_W-1:0] scaled;

  always_comb begin
    need = (SIZE_W+1)'(size) + (SIZE_W+1)'(PTR_BYTES);
    adec.too_large = 1'b1;
    adec.cls       = NO_CLASS;
    // Scan down so the smallest fitting class wins.
    for (int k = NCLASS - 1; k >= 0; k--) begin
      if ((SIZE_W+2)'(need) < ((SIZE_W+2)'(1) << (k + MIN_SHIFT))) begin
        adec.too_large = 1'b0;
        adec.cls       = CLS_W'(k);
      end
    end
  end

  always_comb begin
    rel       = off - BASE;
    fshift    = {1'b0, free_cls} + 5'(MIN_SHIFT);
    mask      = ((OFF_W+1)'(1) << fshift) - (OFF_W+1)'(1);
    slot_full = rel >> fshift;
    nbuf      = bufs_per_page(free_cls, USABLE);
    fdec.slot = slot_full[SLOT_W-1:0];
    fdec.ok   = (free_cls < CLS_W'(NCLASS)) && (off >= BASE)
             && (((OFF_W+1)'(rel) & mask) == '0)
             && (slot_full < OFF_W'(nbuf));
  end

  always_comb begin
    scaled   = (OFF_W+SLOT_W)'(slot) << ({1'b0, addr_cls} + 5'(MIN_SHIFT));
    data_off = BASE + scaled[OFF_W-1:0];
  end

endmodule
`default_nettype wire

### rtl/power_of_two_free_list_allocator_unit.sv
// Allocate: class check, buffer read, write-back; a new page adds a pop with its info
// write and a carve of n buffers, one buffer memory write per cycle. Free: info read,
// check, buffer read, write-back, plus a read and write-back per page handed back when
// the class empties. Failures end at the class or free check, or at the write-back
// for an unallocated buffer. One request at a time; done is a one-cycle strobe. A
// synchronous reset empties all classes, refills the page stack with no clearing pass.
`default_nettype none
`include "power_of_two_free_list_allocator_unit_macros.svh"
module power_of_two_free_list_allocator_unit import p2fla_pkg::*; #(
  parameter int NUM_PAGES      = 64,
  parameter int PTR_BYTES      = 8,
  parameter int PAGE_HDR_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [ADDR_W-1:0] free_addr,
  output logic              busy,
  output logic              done,
  output logic [ADDR_W-1:0] result_addr,
  output logic [1:0]        status,
  output logic [CLS_W-1:0]  size_class
);

  localparam int PW     = $clog2(NUM_PAGES);
  localparam int CW     = PW + 1;
  localparam int BW     = PW + SLOT_W;
  localparam int NBUF   = NUM_PAGES << SLOT_W;
  localparam int INFO_W = CLS_W + 1 + PW;
  localparam int BUF_W  = 2 + BW;
  localparam logic [OFF_W-1:0] USABLE = OFF_W'(PAGE_BYTES - PAGE_HDR_BYTES);

  state_t state, state_next;

  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] faddr_q;
  logic [CLS_W-1:0]  k_q;
  logic [PW-1:0]     page_q;
  logic [SLOT_W-1:0] slot_q;
  logic [BW-1:0]     id_q;
  logic [PW-1:0]     pop_idx_q;
  logic              pop_rst_q;

  logic              cph_v [NCLASS];
  logic [PW-1:0]     cph   [NCLASS];
  logic              cfh_v [NCLASS];
  logic [BW-1:0]     cfh   [NCLASS];
  logic [LIVE_W-1:0] live  [NCLASS];

  logic [CW-1:0]        sp_count;
  logic [CW-1:0]        wm;
  logic                 page_seen;

  logic              stack_we;
  logic [PW-1:0]     stack_waddr;
  logic [PW-1:0]     stack_rdata;
  logic              info_we;
  logic [PW-1:0]     info_waddr, info_raddr;
  logic [INFO_W-1:0] info_wdata, info_rdata;
  logic              buf_we;
  logic [BW-1:0]     buf_waddr;
  logic [BUF_W-1:0]  buf_wdata, buf_rdata;

  logic              finish;
  logic [ADDR_W-1:0] fin_addr;
  status_t           fin_status;
  logic [CLS_W-1:0]  fin_cls;

  alloc_dec_t        adec;
  free_dec_t         fdec;
  logic [OFF_W-1:0]  data_off;

  logic [PAGE_ADDR_W-1:0] fpage6;
  logic [PW-1:0]          fpage;
  logic                   fpage_ok;
  logic [CLS_W-1:0]       owner;
  logic [CW-1:0]          sp_m1;
  logic [PW-1:0]          popped_page;
  logic [SLOT_W:0]        nbuf;
  logic                   last_slot;
  logic [LIVE_W-1:0]      live_dec;

  assign busy   = (state != S_IDLE);
  assign fpage6 = faddr_q[ADDR_W-1:OFF_W];
  assign fpage  = PW'(fpage6);
  assign fpage_ok = (32'(fpage6) < NUM_PAGES);
  // Pages come out of the reset region in ascending order, so a page has its
  // info written exactly when it lies below the count of such pops.
  assign page_seen = (({1'b0, fpage} + wm) < CW'(NUM_PAGES));
  assign owner  = (fpage_ok && page_seen) ? info_rdata[INFO_W-1 -: CLS_W]
                                          : NO_CLASS;
  assign sp_m1  = sp_count - CW'(1);
  // Stack entries below the low-water mark were never written and keep their reset order.
  assign popped_page = pop_rst_q ? (PW'(NUM_PAGES - 1) - pop_idx_q) : stack_rdata;
  assign nbuf      = bufs_per_page(k_q, USABLE);
  assign last_slot = ({1'b0, slot_q} == (nbuf - (SLOT_W+1)'(1)));
  assign live_dec  = (live[k_q] == '0) ? '0 : (live[k_q] - LIVE_W'(1));
  assign info_raddr = (state == S_REL_RD) ? page_q : fpage;

  p2fla_decode #(
    .PTR_BYTES      (PTR_BYTES),
    .PAGE_HDR_BYTES (PAGE_HDR_BYTES)
  ) u_decode (
    .size     (size_q),
    .off      (faddr_q[OFF_W-1:0]),
    .free_cls (owner),
    .slot     (id_q[SLOT_W-1:0]),
    .addr_cls (k_q),
    .adec     (adec),
    .fdec     (fdec),
    .data_off (data_off)
  );

  p2fla_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (page_q),
    .raddr (PW'(sp_m1)),
    .rdata (stack_rdata)
  );

  p2fla_ram #(.WIDTH(INFO_W), .DEPTH(NUM_PAGES)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  p2fla_ram #(.WIDTH(BUF_W), .DEPTH(NBUF)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (id_q),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    stack_we    = 1'b0;
    stack_waddr = PW'(sp_count);
    info_we     = 1'b0;
    info_waddr  = page_q;
    info_wdata  = {NO_CLASS, 1'b0, PW'(0)};
    buf_we      = 1'b0;
    buf_waddr   = id_q;
    buf_wdata   = {1'b0, cfh_v[k_q], cfh[k_q]};
    finish      = 1'b0;
    fin_addr    = faddr_q;
    fin_status  = STAT_OK;
    fin_cls     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (opcode == OP_FREE) ? S_FREE_INFO : S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: begin
        priority if (adec.too_large) begin
          finish     = 1'b1;
          fin_addr   = '0;
          fin_status = STAT_TOO_LARGE;
          state_next = S_IDLE;
        end else if (cfh_v[adec.cls]) begin
          state_next = S_BUF_RD;
        end else if (sp_count == '0) begin
          finish     = 1'b1;
          fin_addr   = '0;
          fin_status = STAT_NO_PAGE;
          fin_cls    = adec.cls;
          state_next = S_IDLE;
        end else begin
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        info_we    = 1'b1;
        info_waddr = popped_page;
        info_wdata = {k_q, cph_v[k_q], cph[k_q]};
        state_next = S_CARVE;
      end
      S_CARVE: begin
        buf_we    = 1'b1;
        buf_waddr = {page_q, slot_q};
        if (last_slot) begin
          state_next = S_BUF_RD;
        end
      end
      S_BUF_RD: begin
        state_next = S_BUF_WB;
      end
      S_BUF_WB: begin
        buf_we     = 1'b1;
        buf_wdata  = {1'b1, buf_rdata[BW:0]};
        finish     = 1'b1;
        fin_addr   = {PAGE_ADDR_W'(id_q[BW-1:SLOT_W]), data_off};
        fin_cls    = k_q;
        state_next = S_IDLE;
      end
      S_FREE_INFO: begin
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (fpage_ok && fdec.ok) begin
          state_next = S_FREE_BUF;
        end else begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FREE_BUF: begin
        state_next = S_FREE_WB;
      end
      S_FREE_WB: begin
        // A buffer that is not currently allocated is a stale or double free.
        if (!buf_rdata[BUF_W-1]) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          buf_we = 1'b1;
          if (live_dec == '0 && cph_v[k_q]) begin
            state_next = S_REL_RD;
          end else begin
            finish     = 1'b1;
            fin_cls    = k_q;
            state_next = S_IDLE;
          end
        end
      end
      S_REL_RD: begin
        state_next = S_REL_WB;
      end
      S_REL_WB: begin
        info_we  = 1'b1;
        stack_we = (sp_count < CW'(NUM_PAGES));
        if (info_rdata[PW]) begin
          state_next = S_REL_RD;
        end else begin
          finish     = 1'b1;
          fin_cls    = k_q;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_addr <= fin_addr;
      status      <= fin_status;
      size_class  <= fin_cls;
    end
    if (rst) begin
      done         <= 1'b0;
      sp_count     <= CW'(NUM_PAGES);
      wm           <= CW'(NUM_PAGES);
      for (int c = 0; c < NCLASS; c++) begin
        cph_v[c] <= 1'b0;
        cfh_v[c] <= 1'b0;
        live[c]  <= '0;
      end
    end else begin
      done <= finish;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            size_q  <= req_size;
            faddr_q <= free_addr;
          end
        end
        S_ALLOC_CHK: begin
          k_q <= adec.cls;
          if (!adec.too_large) begin
            if (cfh_v[adec.cls]) begin
              id_q <= cfh[adec.cls];
            end else if (sp_count != '0) begin
              sp_count  <= sp_m1;
              pop_idx_q <= PW'(sp_m1);
              pop_rst_q <= (sp_m1 < wm);
              if (sp_m1 < wm) begin
                wm <= sp_m1;
              end
            end
          end
        end
        S_POP_WAIT: begin
          page_q                    <= popped_page;
          cph_v[k_q]                <= 1'b1;
          cph[k_q]                  <= popped_page;
          slot_q                    <= '0;
        end
        S_CARVE: begin
          cfh_v[k_q] <= 1'b1;
          cfh[k_q]   <= {page_q, slot_q};
          id_q       <= {page_q, slot_q};
          if (!last_slot) begin
            slot_q <= slot_q + SLOT_W'(1);
          end
        end
        S_BUF_WB: begin
          cfh_v[k_q] <= buf_rdata[BW];
          cfh[k_q]   <= buf_rdata[BW-1:0];
          live[k_q]  <= live[k_q] + LIVE_W'(1);
        end
        S_FREE_CHK: begin
          k_q  <= owner;
          id_q <= {fpage, fdec.slot};
        end
        S_FREE_WB: begin
          if (buf_rdata[BUF_W-1]) begin
            live[k_q] <= live_dec;
            if (live_dec == '0) begin
              cfh_v[k_q] <= 1'b0;
              cph_v[k_q] <= 1'b0;
              page_q     <= cph[k_q];
            end else begin
              cfh_v[k_q] <= 1'b1;
              cfh[k_q]   <= id_q;
            end
          end
        end
        S_REL_WB: begin
          if (sp_count < CW'(NUM_PAGES)) begin
            sp_count <= sp_count + CW'(1);
          end
          page_q <= info_rdata[PW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  `P2FLA_ASSERT_NR(a_reset_idle, rst |=> !busy && !done, "not idle after reset")
  `P2FLA_ASSERT(a_start_busy, start && !busy |=> busy, "request accepted but not busy")
  `P2FLA_ASSERT(a_done_busy, done |-> $past(busy), "result without a request in flight")
  `P2FLA_ASSERT(a_stack_bound, wm <= sp_count && sp_count <= CW'(NUM_PAGES), "bad stack count")
  `P2FLA_ASSERT(a_fail_zero, done && status != STAT_OK |-> result_addr == '0, "failed alloc addr")

endmodule
`default_nettype wire

### tb/power_of_two_free_list_allocator_unit_tb.sv
// Self-checking testbench for the power-of-two free-list allocator.
// It depends on p2fla_pkg and on the power_of_two_free_list_allocator_unit RTL.
`default_nettype none
module power_of_two_free_list_allocator_unit_tb;
  import p2fla_pkg::*;

  localparam int NPAGE = 64;
  localparam int PTRB  = 8;
  localparam int HDRB  = 16;
  localparam int NIL   = -1;
  localparam int CYCLE_LIMIT = 2000000;

  class alloc_scoreboard;
    int pstack[NPAGE];
    int pcount;
    int owner[NPAGE];
    int plink[NPAGE];
    bit touched[NPAGE];
    int cpage_head[NCLASS];
    int cfree_head[NCLASS];
    int blink[NPAGE*256];
    bit balloc[NPAGE*256];
    int live_cnt[NCLASS];
    logic [ADDR_W-1:0] exp_addr[$];
    status_t exp_stat[$];
    logic [CLS_W-1:0] exp_cls[$];
    logic [ADDR_W-1:0] live_addrs[$];
    int errors;

    function new();
      for (int i = 0; i < NPAGE; i++) begin
        pstack[i] = NPAGE - 1 - i;
        owner[i] = NO_CLASS;
        plink[i] = NIL;
        touched[i] = 0;
      end
      pcount = NPAGE;
      for (int i = 0; i < NCLASS; i++) begin
        cpage_head[i] = NIL;
        cfree_head[i] = NIL;
        live_cnt[i] = 0;
      end
      foreach (balloc[i]) balloc[i] = 0;
      errors = 0;
    endfunction

    function int carve_count(int k);
      int n;
      n = (PAGE_BYTES - HDRB) >> (k + 5);
      return (n == 0) ? 1 : n;
    endfunction

    function void push_expect(logic [ADDR_W-1:0] a, status_t s, logic [CLS_W-1:0] c);
      exp_addr.push_back(a);
      exp_stat.push_back(s);
      exp_cls.push_back(c);
    endfunction

    function void drop_live(logic [ADDR_W-1:0] a);
      foreach (live_addrs[i])
        if (live_addrs[i] == a) begin
          live_addrs.delete(i);
          return;
        end
    endfunction

    // Computes the response of one accepted request and updates the shadow pool.
    function void note_request(logic op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] fa);
      int k, p, id, pg, off, rel, slot, nxt;
      logic [ADDR_W-1:0] a;
      if (op == OP_ALLOC) begin
        for (k = 0; k < NCLASS; k++)
          if (int'(sz) + PTRB < (32 << k)) break;
        if (k >= NCLASS) begin
          push_expect('0, STAT_TOO_LARGE, '0);
          return;
        end
        if (cfree_head[k] == NIL) begin
          if (pcount == 0) begin
            push_expect('0, STAT_NO_PAGE, CLS_W'(k));
            return;
          end
          pcount--;
          p = pstack[pcount];
          owner[p] = k;
          touched[p] = 1;
          plink[p] = cpage_head[k];
          cpage_head[k] = p;
          for (int s = 0; s < carve_count(k); s++) begin
            blink[p*256+s] = cfree_head[k];
            balloc[p*256+s] = 0;
            cfree_head[k] = p*256 + s;
          end
        end
        id = cfree_head[k];
        cfree_head[k] = blink[id];
        balloc[id] = 1;
        live_cnt[k]++;
        a = ADDR_W'((id >> 8) * PAGE_BYTES + HDRB + (id & 255) * (32 << k) + PTRB);
        live_addrs.push_back(a);
        push_expect(a, STAT_OK, CLS_W'(k));
      end else begin
        pg = fa / PAGE_BYTES;
        off = fa % PAGE_BYTES;
        k = owner[pg];
        if (k >= NCLASS || off < HDRB + PTRB || ((off - HDRB - PTRB) % (32 << k)) != 0) begin
          push_expect(fa, STAT_OK, '0);
          return;
        end
        rel = off - HDRB - PTRB;
        slot = rel / (32 << k);
        id = pg*256 + slot;
        if (slot >= carve_count(k) || !balloc[id]) begin
          push_expect(fa, STAT_OK, '0);
          return;
        end
        balloc[id] = 0;
        blink[id] = cfree_head[k];
        cfree_head[k] = id;
        drop_live(fa);
        if (live_cnt[k] > 0) live_cnt[k]--;
        if (live_cnt[k] == 0) begin
          p = cpage_head[k];
          while (p != NIL) begin
            nxt = plink[p];
            plink[p] = NIL;
            owner[p] = NO_CLASS;
            if (pcount < NPAGE) begin
              pstack[pcount] = p;
              pcount++;
            end
            p = nxt;
          end
          cpage_head[k] = NIL;
          cfree_head[k] = NIL;
        end
        push_expect(fa, STAT_OK, CLS_W'(k));
      end
    endfunction

    function void check_result(logic [ADDR_W-1:0] a, logic [1:0] s, logic [CLS_W-1:0] c,
                               longint t);
      logic [ADDR_W-1:0] ea;
      status_t es;
      logic [CLS_W-1:0] ec;
      if (exp_addr.size() == 0) begin
        $display("%0t: unexpected response addr=%0h status=%0d class=%0d", t, a, s, c);
        errors++;
        return;
      end
      ea = exp_addr.pop_front();
      es = exp_stat.pop_front();
      ec = exp_cls.pop_front();
      if (a !== ea) begin
        $display("%0t: result_addr expected %0h actual %0h", t, ea, a);
        errors++;
      end
      if (s !== es) begin
        $display("%0t: status expected %0d actual %0d", t, es, s);
        errors++;
      end
      if (c !== ec) begin
        $display("%0t: size_class expected %0d actual %0d", t, ec, c);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, opcode, busy, done;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] free_addr, result_addr;
  logic [1:0] status;
  logic [CLS_W-1:0] size_class;
  alloc_scoreboard sb;
  int cycles;
  int n_sent;

  power_of_two_free_list_allocator_unit dut (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .req_size(req_size),
    .free_addr(free_addr), .busy(busy), .done(done), .result_addr(result_addr),
    .status(status), .size_class(size_class)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(result_addr, status, size_class, $time);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_request(logic op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] fa);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    req_size <= sz;
    free_addr <= fa;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(op, sz, fa);
    n_sent++;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic alloc_class(int k);
    int lo, hi;
    lo = (k == 0) ? 0 : (16 << k) - PTRB;
    hi = (32 << k) - PTRB - 1;
    send_request(OP_ALLOC, SIZE_W'($urandom_range(lo, hi)), ADDR_W'($urandom));
  endtask

  // Frees a live buffer when there is one; otherwise sends a bad free.
  task automatic free_live();
    logic [ADDR_W-1:0] a;
    if (sb.live_addrs.size() == 0) begin
      free_bad();
      return;
    end
    a = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
    send_request(OP_FREE, SIZE_W'($urandom), a);
  endtask

  // Bad frees only target pages that have been owned at least once.
  task automatic free_bad();
    logic [ADDR_W-1:0] a;
    int pg, tries;
    a = ADDR_W'($urandom);
    if (sb.live_addrs.size() > 0 && $urandom_range(0, 1) == 1)
      a = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)]
          + ADDR_W'($urandom_range(1, 16));
    pg = a / PAGE_BYTES;
    tries = 0;
    while (!sb.touched[pg] && tries < NPAGE) begin
      pg = (pg + 1) % NPAGE;
      tries++;
    end
    if (!sb.touched[pg]) return;
    a = ADDR_W'(pg * PAGE_BYTES + (a % PAGE_BYTES));
    send_request(OP_FREE, SIZE_W'($urandom), a);
  endtask

  initial begin
    logic [ADDR_W-1:0] a;
    int r;
    sb = new();
    cycles = 0;
    n_sent = 0;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_ALLOC;
    req_size = '0;
    free_addr = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(OP_ALLOC, 13'd0, '0);
    send_request(OP_ALLOC, 13'd23, '1);
    send_request(OP_ALLOC, 13'd24, '0);
    send_request(OP_ALLOC, 13'd8183, '0);
    send_request(OP_ALLOC, 13'd8184, '0);
    send_request(OP_ALLOC, 13'd8191, '1);
    for (int k = 1; k < 8; k++) alloc_class(k);
    a = sb.live_addrs[0];
    send_request(OP_FREE, '1, a);
    send_request(OP_FREE, '0, a);
    send_request(OP_FREE, '0, a + ADDR_W'(4));
    send_request(OP_FREE, '0, a - ADDR_W'(PTRB));
    // Class 7 carves one buffer per page, so slot one is past the carved count.
    a = sb.live_addrs[sb.live_addrs.size() - 1];
    send_request(OP_FREE, '0, a + ADDR_W'(4096));
    while (sb.live_addrs.size() > 0) send_request(OP_FREE, '0, sb.live_addrs[0]);
    send_request(OP_FREE, '0, 19'd24);

    while (n_sent < 550) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        send_request(OP_ALLOC, SIZE_W'($urandom_range(8184, 8191)), ADDR_W'($urandom));
      else if (r < 25)
        alloc_class(8);
      else if (r < 58)
        alloc_class($urandom_range(0, 7));
      else if (r < 92)
        free_live();
      else
        free_bad();
      // Occasionally drain the pool so classes empty and pages go back.
      if ($urandom_range(0, 199) == 0)
        while (sb.live_addrs.size() > 0) free_live();
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.exp_addr.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.exp_addr.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
